>>> hdl/ti_pkg.sv
package ti_pkg;

  localparam int VOL_W = 48;
  localparam int OUT_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } ti_state_t;

endpackage

>>> hdl/ti_in_if.sv
interface ti_in_if import ti_pkg::*; #(parameter int CW = 24) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] corner_x;
  logic signed [CW-1:0] corner_y;
  logic signed [CW-1:0] corner_z;
  logic [VOL_W-1:0]     tet_volume;

  modport source (output valid, corner_x, corner_y, corner_z, tet_volume, input ready);
  modport sink (input valid, corner_x, corner_y, corner_z, tet_volume, output ready);
endinterface

>>> hdl/ti_out_if.sv
interface ti_out_if import ti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] inradius;
  logic             degenerate;

  modport source (output valid, inradius, degenerate, input ready);
  modport sink (input valid, inradius, degenerate, output ready);
endinterface

>>> hdl/ti_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module ti_mul #(
  parameter int MW = 50
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [MW-1:0]   op_a,
  input  logic [MW-1:0]   op_b,
  output logic            done,
  output logic [2*MW-1:0] prod
);
  localparam int CNT_W = $clog2(MW + 1);

  logic            busy;
  logic [CNT_W-1:0] cnt;
  logic [MW-1:0]   aq;
  logic [MW-1:0]   hi;
  logic [MW-1:0]   lo;
  logic [MW:0]     sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, aq} : {(MW+1){1'b0}});
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        aq   <= op_a;
        hi   <= '0;
        lo   <= op_b;
      end else if (busy) begin
        {hi, lo} <= {sum, lo[MW-1:1]};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(MW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/ti_sqrt.sv
// Restoring integer square root, one root bit per cycle.
module ti_sqrt #(
  parameter int RW = 102
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [RW-1:0]   radicand,
  output logic            done,
  output logic [RW/2-1:0] root
);
  localparam int QW    = RW / 2;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    rad;
  logic [QW+1:0]    rem;
  logic [QW+1:0]    remsh;
  logic [QW+1:0]    trial;
  logic [QW+2:0]    diff;
  logic             ge;

  assign remsh = {rem[QW-1:0], rad[RW-1:RW-2]};
  assign trial = {root, 2'b01};
  assign diff  = {1'b0, remsh} - {1'b0, trial};
  assign ge    = ~diff[QW+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[QW+1:0] : remsh;
        root <= {root[QW-2:0], ge};
        rad  <= {rad[RW-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/ti_div.sv
// Restoring divider, one quotient bit per cycle.
module ti_div #(
  parameter int NW = 51,
  parameter int DW = 53
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dvs;
  logic [DW-1:0]    rem;
  logic [DW:0]      rs;
  logic [DW+1:0]    diff;
  logic             ge;

  assign rs   = {rem, quo[NW-1]};
  assign diff = {1'b0, rs} - {2'b00, dvs};
  assign ge   = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? diff[DW-1:0] : rs[DW-1:0];
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/tetrahedron_inradius.sv
// Flow: corners are taken only in ST_IDLE, one transfer each; the fourth starts the work,
//   and no new corner is taken until the result has been loaded into the output register.
// Cost: the bit-serial multiplier (nine products per face) dominates, then the serial
//   root and divider.
// Reset (rst, synchronous): corner count, FSM and output valid cleared; data regs not reset.
module tetrahedron_inradius import ti_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input logic  clk,
  input logic  rst,
  ti_in_if.sink    corner,
  ti_out_if.source result
);
  localparam int CW  = COORD_WIDTH;
  localparam int D   = CW + 1;          // coordinate difference
  localparam int MW  = 2 * D;           // multiplier operand
  localparam int CXW = 2 * D + 1;       // cross product component
  localparam int RW  = 4 * D + 2;       // sum of squared components
  localparam int QW  = RW / 2;          // face norm
  localparam int NW  = QW + 2;          // sum of four norms
  localparam int DVW = VOL_W + 3;       // 6 * volume

  function automatic logic [D-1:0] mag_d(input logic signed [D-1:0] v);
    mag_d = v[D-1] ? D'(-v) : D'(v);
  endfunction

  function automatic logic [MW-1:0] mag_c(input logic signed [CXW-1:0] v);
    logic [CXW-1:0] t;
    t = v[CXW-1] ? CXW'(-v) : CXW'(v);
    mag_c = t[MW-1:0];
  endfunction

  ti_state_t state, state_next;

  logic [1:0]           cnt;
  logic signed [CW-1:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z, c3x, c3y, c3z;
  logic [VOL_W-1:0]     vol;
  logic signed [CW-1:0] px, py, pz, qx, qy, qz, sx, sy, sz;
  logic signed [D-1:0]  ux, uy, uz, wx, wy, wz;
  logic signed [CXW-1:0] cacc, cx, cy, cz, term;
  logic [RW-1:0]        sqacc;
  logic [NW-1:0]        nsum;
  logic [1:0]           fidx;
  logic [3:0]           step;
  logic [OUT_W-1:0]     res_q;
  logic                 res_deg;
  logic                 out_valid;
  logic [OUT_W-1:0]     out_q;
  logic                 out_deg;

  logic                 acc;
  logic                 out_free;
  logic                 mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
  logic [MW-1:0]        op_a, op_b;
  logic                 sgn;
  logic [2*MW-1:0]      prod;
  logic [QW-1:0]        root;
  logic [DVW-1:0]       quo;
  logic [DVW-1:0]       dividend;

  assign acc       = corner.valid && corner.ready;
  assign out_free  = !out_valid || result.ready;
  assign dividend  = {1'b0, vol, 2'b00} + {2'b00, vol, 1'b0};
  assign term      = prod[CXW-1:0];

  assign result.valid      = out_valid;
  assign result.inradius   = out_q;
  assign result.degenerate = out_deg;

  // face corners: (0,1,2) (0,2,3) (0,1,3) (3,1,2)
  always_comb begin
    px = c0x; py = c0y; pz = c0z;
    qx = c1x; qy = c1y; qz = c1z;
    sx = c2x; sy = c2y; sz = c2z;
    case (fidx)
      2'd1: begin
        qx = c2x; qy = c2y; qz = c2z;
        sx = c3x; sy = c3y; sz = c3z;
      end
      2'd2: begin
        sx = c3x; sy = c3y; sz = c3z;
      end
      2'd3: begin
        px = c3x; py = c3y; pz = c3z;
      end
      default: begin
      end
    endcase
  end

  // product schedule: six cross terms, then three squares
  always_comb begin
    op_a = '0;
    op_b = '0;
    sgn  = 1'b0;
    case (step)
      4'd0: begin
        op_a = MW'(mag_d(uy)); op_b = MW'(mag_d(wz)); sgn = uy[D-1] ^ wz[D-1];
      end
      4'd1: begin
        op_a = MW'(mag_d(uz)); op_b = MW'(mag_d(wy)); sgn = ~(uz[D-1] ^ wy[D-1]);
      end
      4'd2: begin
        op_a = MW'(mag_d(uz)); op_b = MW'(mag_d(wx)); sgn = uz[D-1] ^ wx[D-1];
      end
      4'd3: begin
        op_a = MW'(mag_d(ux)); op_b = MW'(mag_d(wz)); sgn = ~(ux[D-1] ^ wz[D-1]);
      end
      4'd4: begin
        op_a = MW'(mag_d(ux)); op_b = MW'(mag_d(wy)); sgn = ux[D-1] ^ wy[D-1];
      end
      4'd5: begin
        op_a = MW'(mag_d(uy)); op_b = MW'(mag_d(wx)); sgn = ~(uy[D-1] ^ wx[D-1]);
      end
      4'd6: begin
        op_a = mag_c(cx); op_b = mag_c(cx);
      end
      4'd7: begin
        op_a = mag_c(cy); op_b = mag_c(cy);
      end
      4'd8: begin
        op_a = mag_c(cz); op_b = mag_c(cz);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    corner.ready = 1'b0;
    mul_start    = 1'b0;
    sqrt_start   = 1'b0;
    div_start    = 1'b0;
    case (state)
      ST_IDLE: begin
        corner.ready = 1'b1;
        if (corner.valid && cnt == 2'd3) state_next = ST_DIFF;
      end
      ST_DIFF: state_next = ST_MUL_GO;
      ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) state_next = (step == 4'd8) ? ST_SQRT_GO : ST_MUL_GO;
      end
      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) state_next = (fidx == 2'd3) ? ST_DIV_GO : ST_DIFF;
      end
      ST_DIV_GO: begin
        div_start  = (nsum != '0);
        state_next = (nsum == '0) ? ST_OUT : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      // in ST_OUT the output register is reloaded below instead
      if (result.ready && state != ST_OUT) out_valid <= 1'b0;

      if (acc) begin
        cnt <= cnt + 2'd1;
        case (cnt)
          2'd0: begin
            c0x <= corner.corner_x; c0y <= corner.corner_y; c0z <= corner.corner_z;
          end
          2'd1: begin
            c1x <= corner.corner_x; c1y <= corner.corner_y; c1z <= corner.corner_z;
          end
          2'd2: begin
            c2x <= corner.corner_x; c2y <= corner.corner_y; c2z <= corner.corner_z;
          end
          default: begin
            c3x  <= corner.corner_x; c3y <= corner.corner_y; c3z <= corner.corner_z;
            vol  <= corner.tet_volume;
            fidx <= 2'd0;
            nsum <= '0;
          end
        endcase
      end

      case (state)
        ST_DIFF: begin
          ux   <= D'(qx) - D'(px); uy <= D'(qy) - D'(py); uz <= D'(qz) - D'(pz);
          wx   <= D'(sx) - D'(px); wy <= D'(sy) - D'(py); wz <= D'(sz) - D'(pz);
          step <= 4'd0;
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            step <= step + 4'd1;
            if (step < 4'd6) begin
              if (!step[0]) begin
                cacc <= sgn ? -term : term;
              end else begin
                case (step)
                  4'd1: cx <= sgn ? cacc - term : cacc + term;
                  4'd3: cy <= sgn ? cacc - term : cacc + term;
                  default: cz <= sgn ? cacc - term : cacc + term;
                endcase
              end
            end else begin
              sqacc <= ((step == 4'd6) ? '0 : sqacc) + RW'(prod);
            end
          end
        end
        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            nsum <= nsum + NW'(root);
            fidx <= fidx + 2'd1;
          end
        end
        ST_DIV_GO: begin
          // zero total area: flag it and report zero
          if (nsum == '0) begin
            res_q   <= '0;
            res_deg <= 1'b1;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            res_q   <= (|quo[DVW-1:OUT_W]) ? {OUT_W{1'b1}} : quo[OUT_W-1:0];
            res_deg <= 1'b0;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_q     <= res_q;
            out_deg   <= res_deg;
          end
        end
        default: begin
        end
      endcase
    end
  end

  ti_mul #(.MW(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (op_a),
    .op_b  (op_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ti_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqacc),
    .done     (sqrt_done),
    .root     (root)
  );

  ti_div #(.NW(DVW), .DW(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (nsum),
    .done     (div_done),
    .quo      (quo)
  );

`ifndef ASSERT_OFF
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |-> result.inradius == '0)
    else $error("degenerate result with nonzero radius");

  a_start_on_fourth: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && state_next != ST_IDLE |-> acc && cnt == 2'd3)
    else $error("compute started without fourth corner");

  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == ST_SQRT_WAIT)
    else $error("root finished outside its wait state");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL_WAIT)
    else $error("product finished outside its wait state");
`endif
endmodule

>>> verif/tb_tetrahedron_inradius.sv
`timescale 1ns / 100ps

module tb_tetrahedron_inradius;
  import ti_pkg::*;

  localparam int CW = 24;
  localparam int NUM_TETS = 440;       // 1760 corner transfers, plus 24 from the directed tets
  localparam int DRAIN_TET = 120;      // sender waits for an empty pipe before this tet
  localparam int LONG_HOLD = 7000;     // receiver hold-off, in cycles
  localparam int HOLD_AT_TET = 60;     // start hold-off after this many results
  localparam int TAIL_CYCLES = 2400;   // one full tet latency, plus margin
  localparam int WATCHDOG_LIMIT = 30000;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic [VOL_W-1:0]     vol;
    bit                   wait_idle;   // offer only once every result is back
  } corner_t;

  typedef struct {
    logic [OUT_W-1:0] radius;
    logic             degen;
  } radius_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  ti_in_if #(.CW(CW)) corner ();
  ti_out_if           result ();

  tetrahedron_inradius #(.COORD_WIDTH(CW)) uut (
    .clk(clk),
    .rst(rst),
    .corner(corner.sink),
    .result(result.source)
  );

  corner_t corner_q[$];      // corners still to send
  radius_t radius_q[$];      // predicted results, oldest first
  int      errors = 0;
  int      tets_checked = 0;
  int      degen_seen = 0;
  int      sat_seen = 0;
  int      idle_cycles = 0;

  // Predictor state: the three held corners and the index of the next one.
  longint  held[3][3];
  int      next_corner = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
  endtask

  // floor(sqrt(v)), bit by bit from the top
  function automatic logic [63:0] int_sqrt(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] c2;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      c2 = {64'd0, c} * {64'd0, c};
      if (c2 <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [127:0] sq_mag(input longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return {64'd0, m} * {64'd0, m};
  endfunction

  // |(q - p) x (s - p)|, floored
  function automatic logic [63:0] cross_norm(input longint p[3], input longint q[3],
                                             input longint s[3]);
    longint ux, uy, uz, wx, wy, wz;
    longint cx, cy, cz;
    ux = q[0] - p[0]; uy = q[1] - p[1]; uz = q[2] - p[2];
    wx = s[0] - p[0]; wy = s[1] - p[1]; wz = s[2] - p[2];
    cx = uy * wz - uz * wy;
    cy = uz * wx - ux * wz;
    cz = ux * wy - uy * wx;
    return int_sqrt(sq_mag(cx) + sq_mag(cy) + sq_mag(cz));
  endfunction

  // inradius = 6 * volume / (sum of face cross norms), saturated
  function automatic radius_t tet_inradius(input longint p[4][3], input logic [VOL_W-1:0] vol);
    radius_t     res;
    logic [63:0] area2;
    logic [63:0] quo;
    area2 = cross_norm(p[0], p[1], p[2]) + cross_norm(p[0], p[2], p[3])
          + cross_norm(p[0], p[1], p[3]) + cross_norm(p[3], p[1], p[2]);
    if (area2 == 0) begin
      res.radius = '0;
      res.degen = 1'b1;
    end else begin
      quo = ({16'd0, vol} * 64'd6) / area2;
      res.radius = (quo > 64'hFFFF_FFFF) ? '1 : quo[OUT_W-1:0];
      res.degen = 1'b0;
    end
    return res;
  endfunction

  // Runs once per accepted corner; the fourth one yields a prediction.
  task automatic take_corner(input corner_t c);
    longint pts[4][3];
    if (next_corner < 3) begin
      held[next_corner][0] = longint'(c.x);
      held[next_corner][1] = longint'(c.y);
      held[next_corner][2] = longint'(c.z);
      next_corner++;
    end else begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) pts[i][k] = held[i][k];
      pts[3][0] = longint'(c.x); pts[3][1] = longint'(c.y); pts[3][2] = longint'(c.z);
      radius_q.push_back(tet_inradius(pts, c.vol));
      next_corner = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps. A corner flagged
  // wait_idle is held back until every predicted result has come out.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    bit      offer;
    corner_t nxt;
    offer = 1'b0;
    if (rst) begin
      corner.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (corner.valid && corner.ready) begin
        take_corner(corner_q.pop_front());
        idle_cycles = 0;
      end
      // a corner not yet taken stays on the bus unchanged
      if (corner.valid && !corner.ready) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (corner_q.size() > 0 &&
                   !(corner_q[0].wait_idle && radius_q.size() != 0)) begin
        offer = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          // long runs without gaps now and then
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (offer) begin
        nxt = corner_q[0];
        corner.corner_x <= nxt.x;
        corner.corner_y <= nxt.y;
        corner.corner_z <= nxt.z;
        corner.tet_volume <= nxt.vol;
      end
      corner.valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall pattern whose mode is redrawn whenever rx_phase wraps, plus one
  // long hold-off while corners keep coming, so the input side backs up.
  // ---------------------------------------------------------------------------
  int  rx_phase = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    bit rdy;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (!hold_done && tets_checked >= HOLD_AT_TET) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (rx_phase == 0) rx_mode = $urandom_range(0, 3);
      rx_phase = (rx_phase + 1) % 64;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = rx_phase[2];
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      result.ready <= rdy;
    end
  end

  // Monitor: each result against the oldest prediction.
  always @(posedge clk) begin
    radius_t want;
    if (!rst && result.valid && result.ready) begin
      idle_cycles = 0;
      if (radius_q.size() == 0) begin
        report("unexpected result", 64'(result.inradius), 64'd0);
      end else begin
        want = radius_q.pop_front();
        if (result.inradius !== want.radius)
          report("inradius", 64'(result.inradius), 64'(want.radius));
        if (result.degenerate !== want.degen)
          report("degenerate", 64'(result.degenerate), 64'(want.degen));
        if (want.degen) degen_seen++;
        if (want.radius == '1) sat_seen++;
      end
      tets_checked++;
    end
  end

  // Watchdog: too long with no transfer on either side.
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[tetrahedron_inradius] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [CW-1:0] any_coord();
    return CW'($urandom);
  endfunction

  function automatic logic [VOL_W-1:0] any_vol();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return VOL_W'($urandom_range(0, 1 << 20));
      default: return VOL_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic push_tet(input logic signed [CW-1:0] p[4][3], input logic [VOL_W-1:0] vol,
                          input bit wait_idle);
    corner_t c;
    for (int i = 0; i < 4; i++) begin
      c.x = p[i][0]; c.y = p[i][1]; c.z = p[i][2];
      // volume only matters on the last corner; junk elsewhere
      c.vol = (i == 3) ? vol : VOL_W'({$urandom, $urandom});
      c.wait_idle = wait_idle && (i == 0);
      corner_q.push_back(c);
    end
  endtask

  task automatic add_random_tet(input bit wait_idle);
    logic signed [CW-1:0] p[4][3];
    logic signed [CW-1:0] base[3];
    int style;
    int d;
    style = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) base[k] = any_coord();
    d = $urandom_range(1, 3);
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        case (style)
          0, 1, 2, 3: p[i][k] = any_coord();
          // small tet near a random point: tiny area, saturation likely
          4, 5: p[i][k] = CW'(base[k] + $signed($urandom_range(0, 8)) - 4);
          // all corners on one point: degenerate
          6: p[i][k] = base[k];
          // corners on a line: zero area
          7: p[i][k] = CW'(base[k] + i * d * (k + 1));
          // coordinate extremes
          8: p[i][k] = $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
          default: p[i][k] = CW'($signed($urandom_range(0, 65535)) - 32768);
        endcase
    push_tet(p, any_vol(), wait_idle);
  endtask

  task automatic add_directed();
    logic signed [CW-1:0] p[4][3];
    logic signed [CW-1:0] lo, hi;
    lo = {1'b1, {(CW-1){1'b0}}};
    hi = {1'b0, {(CW-1){1'b1}}};
    // all zero corners, max volume: degenerate
    p = '{default: '0};
    push_tet(p, '1, 1'b0);
    // unit corner tet (1.0 = 4096), volume 1/6
    p = '{default: '0};
    p[1][0] = CW'(4096); p[2][1] = CW'(4096); p[3][2] = CW'(4096);
    push_tet(p, 48'd11453246122, 1'b0);
    // smallest nonzero tet with max volume: saturates
    p = '{default: '0};
    p[1][0] = CW'(1); p[2][1] = CW'(1); p[3][2] = CW'(1);
    push_tet(p, '1, 1'b0);
    // coordinate extremes, max volume
    p = '{'{lo, lo, lo}, '{hi, lo, lo}, '{lo, hi, lo}, '{lo, lo, hi}};
    push_tet(p, '1, 1'b0);
    // extremes again, zero volume
    p = '{'{hi, hi, hi}, '{lo, hi, hi}, '{hi, lo, hi}, '{hi, hi, lo}};
    push_tet(p, '0, 1'b0);
    // collinear, nonzero: degenerate
    p[0] = '{CW'(-5), CW'(-5), CW'(-5)};
    p[1] = '{CW'(1), CW'(1), CW'(1)};
    p[2] = '{CW'(7), CW'(7), CW'(7)};
    p[3] = '{hi, hi, hi};
    push_tet(p, 48'd1, 1'b0);
  endtask

  initial begin
    corner.valid = 1'b0;
    corner.corner_x = '0;
    corner.corner_y = '0;
    corner.corner_z = '0;
    corner.tet_volume = '0;
    result.ready = 1'b0;

    add_directed();
    for (int t = 0; t < NUM_TETS; t++) add_random_tet(t == DRAIN_TET);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (corner_q.size() == 0 && !corner.valid);
    wait (radius_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d tetrahedra: %0d degenerate, %0d saturated, with input backpressure",
             tets_checked, degen_seen, sat_seen);
    $display("and one long result hold-off; %0d mismatches", errors);
    if (errors == 0 && radius_q.size() == 0)
      $display("[tetrahedron_inradius] OK");
    else
      $display("[tetrahedron_inradius] ERROR");
    $finish;
  end

endmodule

>>> tetrahedron_inradius.f
hdl/ti_pkg.sv
hdl/ti_in_if.sv
hdl/ti_out_if.sv
hdl/ti_mul.sv
hdl/ti_sqrt.sv
hdl/ti_div.sv
hdl/tetrahedron_inradius.sv
verif/tb_tetrahedron_inradius.sv
